>>> rtl/lsc_pkg.sv
// Shared types, constants and helper functions for the 3D segment clipper.
`default_nettype none

package lsc_pkg;

    // Signed Q16.16 coordinate
    typedef logic signed [31:0] lsc_coord_t;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        LSC_REG_X_LOW  = 3'd0,
        LSC_REG_X_HIGH = 3'd1,
        LSC_REG_Y_LOW  = 3'd2,
        LSC_REG_Y_HIGH = 3'd3,
        LSC_REG_Z_LOW  = 3'd4,
        LSC_REG_Z_HIGH = 3'd5
    } lsc_reg_t;

    localparam lsc_coord_t LSC_COORD_MIN = 32'sh8000_0000;
    localparam lsc_coord_t LSC_COORD_MAX = 32'sh7FFF_FFFF;

    // Quotient magnitude clamp (2^34) and the saturation limits of the final sum
    localparam logic [34:0]        LSC_QCLAMP  = 35'h4_0000_0000;
    localparam logic signed [35:0] LSC_SAT_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] LSC_SAT_MIN = -36'sh0_8000_0000;

    // Interpolator pipeline depth, and start-to-done latency of the block
    localparam int LSC_INTERP_LAT = 9;
    localparam int LSC_LATENCY    = 3 * LSC_INTERP_LAT + 3;

    // One segment in flight: original and current endpoints, index 0..2 start, 3..5 end
    typedef struct packed {
        logic             bypass;
        logic             vis;
        lsc_coord_t [5:0] org;
        lsc_coord_t [5:0] cur;
    } lsc_seg_t;

    // Segment plus the clip decision of one pass
    typedef struct packed {
        lsc_seg_t         seg;
        logic       [1:0] clip;
        lsc_coord_t [1:0] face;
    } lsc_pass_t;

    // One restoring division step: returns {quotient bit, new remainder}
    function automatic logic [32:0] lsc_div_step(input logic [31:0] r, input logic b,
                                                 input logic [31:0] d);
        logic [32:0] rw;
        logic [32:0] df;
        rw = {r, b};
        df = rw - {1'b0, d};
        if (rw >= {1'b0, d})
            return {1'b1, df[31:0]};
        else
            return {1'b0, rw[31:0]};
    endfunction

    // Inclusive containment of one point
    function automatic logic lsc_pt_in(input lsc_coord_t [2:0] p, input lsc_coord_t [2:0] lo,
                                       input lsc_coord_t [2:0] hi);
        return !($signed(p[0]) < $signed(lo[0]) || $signed(p[0]) > $signed(hi[0]) ||
                 $signed(p[1]) < $signed(lo[1]) || $signed(p[1]) > $signed(hi[1]) ||
                 $signed(p[2]) < $signed(lo[2]) || $signed(p[2]) > $signed(hi[2]));
    endfunction

    // Rotate axes (a,b,c) -> (b,c,a) on both endpoints
    function automatic lsc_seg_t lsc_rot(input lsc_seg_t s);
        lsc_seg_t r;
        r = s;
        r.org[0] = s.org[1]; r.org[1] = s.org[2]; r.org[2] = s.org[0];
        r.org[3] = s.org[4]; r.org[4] = s.org[5]; r.org[5] = s.org[3];
        r.cur[0] = s.cur[1]; r.cur[1] = s.cur[2]; r.cur[2] = s.cur[0];
        r.cur[3] = s.cur[4]; r.cur[4] = s.cur[5]; r.cur[5] = s.cur[3];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lsc_interp.sv
// Pipelined interpolator: o1 + (o2-o1)*(f-a1)/(a2-a1), truncated, clamped, saturated.
`default_nettype none

module lsc_interp (
    input  wire logic               clk,
    input  wire lsc_pkg::lsc_coord_t o1,
    input  wire lsc_pkg::lsc_coord_t o2,
    input  wire lsc_pkg::lsc_coord_t f,
    input  wire lsc_pkg::lsc_coord_t a1,
    input  wire lsc_pkg::lsc_coord_t a2,
    output lsc_pkg::lsc_coord_t      result
);

    // Differences, magnitudes and sign
    logic signed [32:0] dn, df, dd;
    logic signed [32:0] dn_m, df_m, dd_m;
    assign dn   = 33'(o2) - 33'(o1);
    assign df   = 33'(f)  - 33'(a1);
    assign dd   = 33'(a2) - 33'(a1);
    assign dn_m = dn[32] ? -dn : dn;
    assign df_m = df[32] ? -df : df;
    assign dd_m = dd[32] ? -dd : dd;

    logic [31:0]         a_reg, b_reg, d_reg;
    logic                neg_reg, zero_reg;
    lsc_pkg::lsc_coord_t o1_reg;

    always_ff @(posedge clk)
    begin
        a_reg    <= dn_m[31:0];
        b_reg    <= df_m[31:0];
        d_reg    <= dd_m[31:0];
        neg_reg  <= dn[32] ^ df[32] ^ dd[32];
        zero_reg <= (dn == 33'sd0) || (df == 33'sd0) || (dd == 33'sd0);
        o1_reg   <= o1;
    end

    // Product stage
    logic [63:0]         prod_reg;
    logic [31:0]         m_d_reg;
    logic                m_neg_reg, m_zero_reg;
    lsc_pkg::lsc_coord_t m_o1_reg;

    always_ff @(posedge clk)
    begin
        prod_reg   <= {32'd0, a_reg} * {32'd0, b_reg};
        m_d_reg    <= d_reg;
        m_neg_reg  <= neg_reg;
        m_zero_reg <= zero_reg;
        m_o1_reg   <= o1_reg;
    end

    // Division stages: overflow check plus 5 bits, then 6 bits per stage
    logic [31:0]         r_reg     [6];
    logic [34:0]         q_reg     [6];
    logic [34:0]         lb_reg    [6];
    logic [31:0]         dv_reg    [6];
    logic                clamp_reg [6];
    logic                dneg_reg  [6];
    logic                dzero_reg [6];
    lsc_pkg::lsc_coord_t do1_reg   [6];

    for (genvar g = 0; g < 6; g++)
    begin : g_div
        localparam int NSTEP = (g == 0) ? 5 : 6;
        logic [31:0]         r_in, r_c;
        logic [34:0]         q_in, q_c;
        logic [34:0]         lb_in, lb_c;
        logic [31:0]         d_in;
        logic                clamp_in;
        logic                dneg_in, dzero_in;
        lsc_pkg::lsc_coord_t do1_in;
        logic [32:0]         st;

        if (g == 0)
        begin : g_first
            logic [31:0] hi;
            assign hi       = {3'd0, prod_reg[63:35]};
            assign clamp_in = hi >= m_d_reg;
            assign r_in     = clamp_in ? 32'd0 : hi;
            assign q_in     = 35'd0;
            assign lb_in    = prod_reg[34:0];
            assign d_in     = m_d_reg;
            assign dneg_in  = m_neg_reg;
            assign dzero_in = m_zero_reg;
            assign do1_in   = m_o1_reg;
        end
        else
        begin : g_next
            assign clamp_in = clamp_reg[g-1];
            assign r_in     = r_reg[g-1];
            assign q_in     = q_reg[g-1];
            assign lb_in    = lb_reg[g-1];
            assign d_in     = dv_reg[g-1];
            assign dneg_in  = dneg_reg[g-1];
            assign dzero_in = dzero_reg[g-1];
            assign do1_in   = do1_reg[g-1];
        end

        always_comb
        begin
            r_c  = r_in;
            q_c  = q_in;
            lb_c = lb_in;
            st   = 33'd0;
            for (int s = 0; s < NSTEP; s++)
            begin
                st   = lsc_pkg::lsc_div_step(r_c, lb_c[34], d_in);
                r_c  = st[31:0];
                q_c  = {q_c[33:0], st[32]};
                lb_c = {lb_c[33:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[g]     <= r_c;
            q_reg[g]     <= q_c;
            lb_reg[g]    <= lb_c;
            dv_reg[g]    <= d_in;
            clamp_reg[g] <= clamp_in;
            dneg_reg[g]  <= dneg_in;
            dzero_reg[g] <= dzero_in;
            do1_reg[g]   <= do1_in;
        end
    end

    // Clamp, apply sign, add base and saturate
    logic [34:0]        qv;
    logic signed [35:0] o1x, qx, sum;
    lsc_pkg::lsc_coord_t res_c, res_reg;

    always_comb
    begin
        qv  = (clamp_reg[5] || q_reg[5] > lsc_pkg::LSC_QCLAMP) ? lsc_pkg::LSC_QCLAMP
                                                                : q_reg[5];
        o1x = 36'(do1_reg[5]);
        qx  = $signed({1'b0, qv});
        sum = dneg_reg[5] ? (o1x - qx) : (o1x + qx);
        if (dzero_reg[5])
            res_c = do1_reg[5];
        else if (sum > lsc_pkg::LSC_SAT_MAX)
            res_c = lsc_pkg::LSC_COORD_MAX;
        else if (sum < lsc_pkg::LSC_SAT_MIN)
            res_c = lsc_pkg::LSC_COORD_MIN;
        else
            res_c = sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_c;
    end

    assign result = res_reg;

endmodule

`default_nettype wire

>>> rtl/lsc_pass.sv
// One clipping pass on axis 0 of a rotated segment, with four interpolators.
`default_nettype none

module lsc_pass (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire lsc_pkg::lsc_seg_t   in_seg,
    input  wire lsc_pkg::lsc_coord_t lo,
    input  wire lsc_pkg::lsc_coord_t hi,
    output logic                     out_valid,
    output lsc_pkg::lsc_seg_t        out_seg
);

    // Clip decision for each endpoint
    lsc_pkg::lsc_pass_t pin;

    always_comb
    begin
        pin.seg     = in_seg;
        pin.clip[0] = !in_seg.bypass && ($signed(in_seg.cur[0]) < $signed(lo) ||
                                         $signed(in_seg.cur[0]) > $signed(hi));
        pin.clip[1] = !in_seg.bypass && ($signed(in_seg.cur[3]) < $signed(lo) ||
                                         $signed(in_seg.cur[3]) > $signed(hi));
        pin.face[0] = ($signed(in_seg.cur[0]) < $signed(lo)) ? lo : hi;
        pin.face[1] = ($signed(in_seg.cur[3]) < $signed(lo)) ? lo : hi;
    end

    // Interpolated coordinates of the other two axes
    lsc_pkg::lsc_coord_t s1, s2, e1, e2;

    lsc_interp u_s1 (.clk(clk), .o1(in_seg.org[1]), .o2(in_seg.org[4]), .f(pin.face[0]),
                     .a1(in_seg.org[0]), .a2(in_seg.org[3]), .result(s1));
    lsc_interp u_s2 (.clk(clk), .o1(in_seg.org[2]), .o2(in_seg.org[5]), .f(pin.face[0]),
                     .a1(in_seg.org[0]), .a2(in_seg.org[3]), .result(s2));
    lsc_interp u_e1 (.clk(clk), .o1(in_seg.org[1]), .o2(in_seg.org[4]), .f(pin.face[1]),
                     .a1(in_seg.org[0]), .a2(in_seg.org[3]), .result(e1));
    lsc_interp u_e2 (.clk(clk), .o1(in_seg.org[2]), .o2(in_seg.org[5]), .f(pin.face[1]),
                     .a1(in_seg.org[0]), .a2(in_seg.org[3]), .result(e2));

    // Delay line matching the interpolator depth
    lsc_pkg::lsc_pass_t                            dly_reg   [lsc_pkg::LSC_INTERP_LAT];
    logic [lsc_pkg::LSC_INTERP_LAT-1:0]            vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[lsc_pkg::LSC_INTERP_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        dly_reg[0] <= pin;
        for (int k = 1; k < lsc_pkg::LSC_INTERP_LAT; k++)
            dly_reg[k] <= dly_reg[k-1];
    end

    // Merge clipped endpoints
    lsc_pkg::lsc_pass_t last;
    assign last = dly_reg[lsc_pkg::LSC_INTERP_LAT-1];

    always_comb
    begin
        out_seg = last.seg;
        if (last.clip[0])
        begin
            out_seg.cur[0] = last.face[0];
            out_seg.cur[1] = s1;
            out_seg.cur[2] = s2;
        end
        if (last.clip[1])
        begin
            out_seg.cur[3] = last.face[1];
            out_seg.cur[4] = e1;
            out_seg.cur[5] = e2;
        end
    end

    assign out_valid = vld_reg[lsc_pkg::LSC_INTERP_LAT-1];

endmodule

`default_nettype wire

>>> rtl/line_segment_clip_3d.sv
// Top level of the 3D segment clipper against a configurable box.
//
// Usage: drive the six endpoint coordinates (signed Q16.16) with start high;
// a segment beat is taken on every clock edge with start high and busy low.
// busy is always low: one segment can be taken every cycle.
// Each result appears on clip_* and visible for one cycle with done high,
// after two entry stages, three clipping passes and one output stage. The
// pass depth is set by the interpolator: subtract, 32x32 multiply, six stages
// of a restoring divider, then sign and saturation.
// Results leave in the order segments came in; the receiver cannot stall.
// Box bounds are written through cfg_write/cfg_index/cfg_data, indexes 0..5 as
// x low, x high, y low, y high, z low, z high; other indexes are ignored.
// Write them only while no segment is in flight.
// Reset (rst_n low, asynchronous) empties the pipeline and opens the box to
// the full coordinate range.
`default_nettype none

module line_segment_clip_3d (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire lsc_pkg::lsc_coord_t start_x,
    input  wire lsc_pkg::lsc_coord_t start_y,
    input  wire lsc_pkg::lsc_coord_t start_z,
    input  wire lsc_pkg::lsc_coord_t end_x,
    input  wire lsc_pkg::lsc_coord_t end_y,
    input  wire lsc_pkg::lsc_coord_t end_z,
    input  wire logic                cfg_write,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    output logic                     done,
    output lsc_pkg::lsc_coord_t      clip_start_x,
    output lsc_pkg::lsc_coord_t      clip_start_y,
    output lsc_pkg::lsc_coord_t      clip_start_z,
    output lsc_pkg::lsc_coord_t      clip_end_x,
    output lsc_pkg::lsc_coord_t      clip_end_y,
    output lsc_pkg::lsc_coord_t      clip_end_z,
    output logic                     visible
);

    assign busy = 1'b0;

    // Box registers
    lsc_pkg::lsc_coord_t [2:0] box_lo_reg, box_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_lo_reg <= {3{lsc_pkg::LSC_COORD_MIN}};
            box_hi_reg <= {3{lsc_pkg::LSC_COORD_MAX}};
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lsc_pkg::LSC_REG_X_LOW:  box_lo_reg[0] <= cfg_data;
                lsc_pkg::LSC_REG_X_HIGH: box_hi_reg[0] <= cfg_data;
                lsc_pkg::LSC_REG_Y_LOW:  box_lo_reg[1] <= cfg_data;
                lsc_pkg::LSC_REG_Y_HIGH: box_hi_reg[1] <= cfg_data;
                lsc_pkg::LSC_REG_Z_LOW:  box_lo_reg[2] <= cfg_data;
                lsc_pkg::LSC_REG_Z_HIGH: box_hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Entry stage: capture the beat
    logic                      s0_valid_reg;
    lsc_pkg::lsc_coord_t [5:0] s0_org_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s0_org_reg <= {end_z, end_y, end_x, start_z, start_y, start_x};
    end

    // Trivial accept and reject
    logic              in0, in1, reject;
    lsc_pkg::lsc_seg_t s1_c;

    always_comb
    begin
        in0    = lsc_pkg::lsc_pt_in(s0_org_reg[2:0], box_lo_reg, box_hi_reg);
        in1    = lsc_pkg::lsc_pt_in(s0_org_reg[5:3], box_lo_reg, box_hi_reg);
        reject = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (($signed(s0_org_reg[k]) < $signed(box_lo_reg[k]) &&
                 $signed(s0_org_reg[k+3]) < $signed(box_lo_reg[k])) ||
                ($signed(s0_org_reg[k]) > $signed(box_hi_reg[k]) &&
                 $signed(s0_org_reg[k+3]) > $signed(box_hi_reg[k])))
                reject = 1'b1;
        end
        s1_c.bypass = (in0 && in1) || reject;
        s1_c.vis    = in0 && in1;
        s1_c.org    = s0_org_reg;
        s1_c.cur    = s0_org_reg;
    end

    logic              s1_valid_reg;
    lsc_pkg::lsc_seg_t s1_seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_seg_reg <= s1_c;
    end

    // Three passes: x, then y, then z, rotating axes in between
    logic              px_valid, py_valid, pz_valid;
    lsc_pkg::lsc_seg_t px_seg, py_seg, pz_seg;

    lsc_pass u_pass_x (.clk(clk), .rst_n(rst_n), .in_valid(s1_valid_reg), .in_seg(s1_seg_reg),
                       .lo(box_lo_reg[0]), .hi(box_hi_reg[0]),
                       .out_valid(px_valid), .out_seg(px_seg));
    lsc_pass u_pass_y (.clk(clk), .rst_n(rst_n), .in_valid(px_valid),
                       .in_seg(lsc_pkg::lsc_rot(px_seg)),
                       .lo(box_lo_reg[1]), .hi(box_hi_reg[1]),
                       .out_valid(py_valid), .out_seg(py_seg));
    lsc_pass u_pass_z (.clk(clk), .rst_n(rst_n), .in_valid(py_valid),
                       .in_seg(lsc_pkg::lsc_rot(py_seg)),
                       .lo(box_lo_reg[2]), .hi(box_hi_reg[2]),
                       .out_valid(pz_valid), .out_seg(pz_seg));

    // Back to x,y,z order and final containment test
    lsc_pkg::lsc_seg_t fin;
    logic              vis_c;
    assign fin   = lsc_pkg::lsc_rot(pz_seg);
    assign vis_c = fin.bypass ? fin.vis :
                   (lsc_pkg::lsc_pt_in(fin.cur[2:0], box_lo_reg, box_hi_reg) &&
                    lsc_pkg::lsc_pt_in(fin.cur[5:3], box_lo_reg, box_hi_reg));

    logic                      done_reg;
    logic                      vis_reg;
    lsc_pkg::lsc_coord_t [5:0] out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= pz_valid;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= fin.cur;
        vis_reg <= vis_c;
    end

    assign done         = done_reg;
    assign visible      = vis_reg;
    assign clip_start_x = out_reg[0];
    assign clip_start_y = out_reg[1];
    assign clip_start_z = out_reg[2];
    assign clip_end_x   = out_reg[3];
    assign clip_end_y   = out_reg[4];
    assign clip_end_z   = out_reg[5];

    // Every taken beat gives one result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(lsc_pkg::LSC_LATENCY) done)
        else $error("taken segment produced no result on time");

    // No result without a segment taken at the matching edge
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, lsc_pkg::LSC_LATENCY))
        else $error("result without a matching segment");

    // Trivially accepted or rejected segments leave the passes unchanged
    a_bypass_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (pz_valid && fin.bypass) |-> (fin.cur == fin.org))
        else $error("bypassed segment was modified");

endmodule

`default_nettype wire
